FILE: rtl/core/tvg_pkg.sv
package tvg_pkg;

  localparam int MAX_SEGMENTS_DEF  = 1024;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int IDX_W   = 11;
  localparam int RAD_W   = 16;
  localparam int PHASE_W = 32;
  localparam int TEX_W   = 17;
  localparam int TRIG_W  = 16;
  localparam int CVAL_W  = 34;

  localparam logic [CVAL_W-1:0] GAIN_Q30 = 34'd652032874;

  localparam logic [1:0] REG_MAJOR_RADIUS   = 2'd0;
  localparam logic [1:0] REG_MINOR_RADIUS   = 2'd1;
  localparam logic [1:0] REG_MAJOR_SEGMENTS = 2'd2;
  localparam logic [1:0] REG_MINOR_SEGMENTS = 2'd3;

  localparam logic [RAD_W-1:0] MAJOR_RADIUS_RST   = 16'd256;
  localparam logic [RAD_W-1:0] MINOR_RADIUS_RST   = 16'd64;
  localparam logic [IDX_W-1:0] MAJOR_SEGMENTS_RST = 11'd32;
  localparam logic [IDX_W-1:0] MINOR_SEGMENTS_RST = 11'd16;

  // Arctangent of 2^-k in turns, scaled by 2^32.
  function automatic logic [31:0] atan_turns(input int k);
    logic [31:0] v;
    case (k)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/tvg_div_cell.sv
module tvg_div_cell #(
  parameter int DW = 43,
  parameter int QW = 32
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tvg_pkg::IDX_W-1:0]   divisor,
  input  logic [tvg_pkg::IDX_W-1:0]   rem_in,
  input  logic [DW-1:0]               num_in,
  input  logic [QW-1:0]               quo_in,
  output logic [tvg_pkg::IDX_W-1:0]   rem_out,
  output logic [DW-1:0]               num_out,
  output logic [QW-1:0]               quo_out
);

  logic [tvg_pkg::IDX_W:0] trial;
  logic [tvg_pkg::IDX_W:0] diff;
  logic                    ge;

  assign trial = {rem_in, num_in[DW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[tvg_pkg::IDX_W-1:0] : trial[tvg_pkg::IDX_W-1:0];
      num_out <= {num_in[DW-2:0], 1'b0};
      quo_out <= {quo_in[QW-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/tvg_divider.sv
// Restoring divider, one quotient bit per cell; keeps the low QW quotient bits.
module tvg_divider #(
  parameter int DW = 43,
  parameter int QW = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tvg_pkg::IDX_W-1:0] divisor,
  input  logic [DW-1:0]             num,
  output logic [QW-1:0]             quo
);

  logic [tvg_pkg::IDX_W-1:0] rem_c [0:DW];
  logic [DW-1:0]             num_c [0:DW];
  logic [QW-1:0]             quo_c [0:DW];

  assign rem_c[0] = '0;
  assign num_c[0] = num;
  assign quo_c[0] = '0;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    tvg_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (divisor),
      .rem_in  (rem_c[k]),
      .num_in  (num_c[k]),
      .quo_in  (quo_c[k]),
      .rem_out (rem_c[k+1]),
      .num_out (num_c[k+1]),
      .quo_out (quo_c[k+1])
    );
  end

  assign quo = quo_c[DW];

endmodule

FILE: rtl/core/tvg_cordic_cell.sv
module tvg_cordic_cell #(
  parameter int K = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tvg_pkg::CVAL_W-1:0] x_in,
  input  logic signed [tvg_pkg::CVAL_W-1:0] y_in,
  input  logic signed [tvg_pkg::CVAL_W-1:0] z_in,
  input  logic [1:0]                       quad_in,
  output logic signed [tvg_pkg::CVAL_W-1:0] x_out,
  output logic signed [tvg_pkg::CVAL_W-1:0] y_out,
  output logic signed [tvg_pkg::CVAL_W-1:0] z_out,
  output logic [1:0]                       quad_out
);

  localparam logic [tvg_pkg::CVAL_W-1:0] ANGLE =
    {{(tvg_pkg::CVAL_W-32){1'b0}}, tvg_pkg::atan_turns(K)};

  logic signed [tvg_pkg::CVAL_W-1:0] xs;
  logic signed [tvg_pkg::CVAL_W-1:0] ys;

  assign xs = x_in >>> K;
  assign ys = y_in >>> K;

  always_ff @(posedge clk) begin
    if (en) begin
      quad_out <= quad_in;
      if (!z_in[tvg_pkg::CVAL_W-1]) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - $signed(ANGLE);
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + $signed(ANGLE);
      end
    end
  end

endmodule

FILE: rtl/core/tvg_cordic.sv
// Sine and cosine of a 32-bit phase in turns.
module tvg_cordic #(
  parameter int STAGES = tvg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [tvg_pkg::PHASE_W-1:0]        phase,
  output logic signed [tvg_pkg::TRIG_W-1:0]  cos_q15,
  output logic signed [tvg_pkg::TRIG_W-1:0]  sin_q15
);

  localparam int W = tvg_pkg::CVAL_W;

  logic signed [W-1:0] x_c [0:STAGES];
  logic signed [W-1:0] y_c [0:STAGES];
  logic signed [W-1:0] z_c [0:STAGES];
  logic [1:0]          q_c [0:STAGES];

  logic [tvg_pkg::PHASE_W-1:0] ph_off;
  logic [1:0]                  quad;
  logic [tvg_pkg::PHASE_W-1:0] resid;

  // Nearest quarter turn first; the residual stays within one eighth turn.
  assign ph_off = phase + 32'h2000_0000;
  assign quad   = ph_off[31:30];
  assign resid  = phase - {quad, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      x_c[0] <= tvg_pkg::GAIN_Q30;
      y_c[0] <= '0;
      z_c[0] <= W'($signed(resid));
      q_c[0] <= quad;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    tvg_cordic_cell #(.K(k)) u_cell (
      .clk      (clk),
      .en       (en),
      .x_in     (x_c[k]),
      .y_in     (y_c[k]),
      .z_in     (z_c[k]),
      .quad_in  (q_c[k]),
      .x_out    (x_c[k+1]),
      .y_out    (y_c[k+1]),
      .z_out    (z_c[k+1]),
      .quad_out (q_c[k+1])
    );
  end

  function automatic logic signed [15:0] round_sat(input logic signed [W-1:0] v);
    logic signed [W-1:0]  s;
    logic signed [W-16:0] r;
    s = v + W'(16384);
    r = s[W-1:15];
    if (r > 32767) return 16'sd32767;
    if (r < -32767) return -16'sd32767;
    return r[15:0];
  endfunction

  logic signed [15:0] cr;
  logic signed [15:0] sr;

  assign cr = round_sat(x_c[STAGES]);
  assign sr = round_sat(y_c[STAGES]);

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_c[STAGES])
        2'd0: begin
          cos_q15 <= cr;
          sin_q15 <= sr;
        end
        2'd1: begin
          cos_q15 <= -sr;
          sin_q15 <= cr;
        end
        2'd2: begin
          cos_q15 <= -cr;
          sin_q15 <= -sr;
        end
        default: begin
          cos_q15 <= sr;
          sin_q15 <= -cr;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/torus_vertex_generator.sv
// Torus vertex generator: each input beat carries one grid point (ring index, tube index) and
// yields one output beat with the vertex position (1/256 units), unit normal (Q1.15), texture
// coordinates (Q1.16) and an out-of-range flag. The pipeline accepts one beat per cycle. Each
// angle phase is formed by 43 restoring-divider cells, followed by the CORDIC input register,
// the CORDIC cells, a rounding stage and four multiply stages. When the output beat is not
// taken the whole pipeline holds. Registers are to be written through the APB port only while
// no beat is in flight; the block itself does not enforce this.
module torus_vertex_generator #(
  parameter int MAX_SEGMENTS  = tvg_pkg::MAX_SEGMENTS_DEF,
  parameter int CORDIC_STAGES = tvg_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // [10:0] ring_index, [21:11] tube_index, [23:22] zero
  input  logic [23:0]   s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // [17:0] pos_x, [34:18] pos_y, [52:35] pos_z, [68:53] norm_x, [84:69] norm_y,
  // [100:85] norm_z, [117:101] tex_u, [134:118] tex_v, [135] zero
  output logic [135:0]  m_tdata,
  // [0] out_of_range
  output logic          m_tuser,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int IW    = tvg_pkg::IDX_W;
  localparam int PH_DW = IW + tvg_pkg::PHASE_W;
  localparam int TX_DW = IW + 16;
  localparam int LAT   = PH_DW + CORDIC_STAGES + 6;
  localparam int TX_DL = LAT - TX_DW;

  // Configuration registers.
  logic [15:0]   major_radius;
  logic [15:0]   minor_radius;
  logic [IW-1:0] major_segments;
  logic [IW-1:0] minor_segments;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius   <= tvg_pkg::MAJOR_RADIUS_RST;
      minor_radius   <= tvg_pkg::MINOR_RADIUS_RST;
      major_segments <= tvg_pkg::MAJOR_SEGMENTS_RST;
      minor_segments <= tvg_pkg::MINOR_SEGMENTS_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        tvg_pkg::REG_MAJOR_RADIUS:   major_radius   <= pwdata[15:0];
        tvg_pkg::REG_MINOR_RADIUS:   minor_radius   <= pwdata[15:0];
        tvg_pkg::REG_MAJOR_SEGMENTS: major_segments <= pwdata[IW-1:0];
        tvg_pkg::REG_MINOR_SEGMENTS: minor_segments <= pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tvg_pkg::REG_MAJOR_RADIUS:   prdata = {16'b0, major_radius};
      tvg_pkg::REG_MINOR_RADIUS:   prdata = {16'b0, minor_radius};
      tvg_pkg::REG_MAJOR_SEGMENTS: prdata = {{(32-IW){1'b0}}, major_segments};
      tvg_pkg::REG_MINOR_SEGMENTS: prdata = {{(32-IW){1'b0}}, minor_segments};
      default:                     prdata = '0;
    endcase
  end

  // A count of zero acts as one; a count above the limit acts as the limit.
  function automatic logic [IW-1:0] eff_count(input logic [IW-1:0] n);
    if (n == '0) return IW'(1);
    if (32'(n) > 32'(MAX_SEGMENTS)) return IW'(MAX_SEGMENTS);
    return n;
  endfunction

  logic [IW-1:0] nmaj;
  logic [IW-1:0] nmin;

  assign nmaj = eff_count(major_segments);
  assign nmin = eff_count(minor_segments);

  // Pipeline control.
  logic [LAT-1:0] vld;
  logic           en;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  logic [IW-1:0] ring_index;
  logic [IW-1:0] tube_index;

  assign ring_index = s_tdata[IW-1:0];
  assign tube_index = s_tdata[2*IW-1:IW];

  // Angle phases and texture coordinates.
  logic [tvg_pkg::PHASE_W-1:0] ph_ring;
  logic [tvg_pkg::PHASE_W-1:0] ph_tube;
  logic [TX_DW-1:0]            tq_ring;
  logic [TX_DW-1:0]            tq_tube;

  tvg_divider #(.DW(PH_DW), .QW(tvg_pkg::PHASE_W)) u_ph_ring (
    .clk (clk), .en (en), .divisor (nmaj),
    .num ({ring_index, {tvg_pkg::PHASE_W{1'b0}}}), .quo (ph_ring)
  );

  tvg_divider #(.DW(PH_DW), .QW(tvg_pkg::PHASE_W)) u_ph_tube (
    .clk (clk), .en (en), .divisor (nmin),
    .num ({tube_index, {tvg_pkg::PHASE_W{1'b0}}}), .quo (ph_tube)
  );

  // Half the count sits below the zero low half of index * 65536, so it packs in.
  tvg_divider #(.DW(TX_DW), .QW(TX_DW)) u_tx_ring (
    .clk (clk), .en (en), .divisor (nmaj),
    .num ({ring_index, 6'b0, nmaj[IW-1:1]}), .quo (tq_ring)
  );

  tvg_divider #(.DW(TX_DW), .QW(TX_DW)) u_tx_tube (
    .clk (clk), .en (en), .divisor (nmin),
    .num ({tube_index, 6'b0, nmin[IW-1:1]}), .quo (tq_tube)
  );

  function automatic logic [tvg_pkg::TEX_W-1:0] tex_sat(input logic [TX_DW-1:0] q);
    if (q > TX_DW'(65536)) return tvg_pkg::TEX_W'(65536);
    return q[tvg_pkg::TEX_W-1:0];
  endfunction

  logic [tvg_pkg::TEX_W-1:0] u_dly [0:TX_DL-1];
  logic [tvg_pkg::TEX_W-1:0] v_dly [0:TX_DL-1];
  logic                      oor_dly [0:LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      u_dly[0]   <= tex_sat(tq_ring);
      v_dly[0]   <= tex_sat(tq_tube);
      oor_dly[0] <= (ring_index > nmaj) || (tube_index > nmin);
      for (int k = 1; k < TX_DL; k++) begin
        u_dly[k] <= u_dly[k-1];
        v_dly[k] <= v_dly[k-1];
      end
      for (int k = 1; k < LAT; k++) begin
        oor_dly[k] <= oor_dly[k-1];
      end
    end
  end

  // Sine and cosine.
  logic signed [15:0] ct;
  logic signed [15:0] st;
  logic signed [15:0] cp;
  logic signed [15:0] sp;

  tvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ring (
    .clk (clk), .en (en), .phase (ph_ring), .cos_q15 (ct), .sin_q15 (st)
  );

  tvg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_tube (
    .clk (clk), .en (en), .phase (ph_tube), .cos_q15 (cp), .sin_q15 (sp)
  );

  // Multiply stages.
  logic signed [32:0] rcp1;
  logic signed [32:0] rsp1;
  logic signed [31:0] nx1;
  logic signed [31:0] nz1;
  logic signed [15:0] ny1;
  logic signed [15:0] ct1;
  logic signed [15:0] st1;

  logic signed [33:0] tube2;
  logic signed [16:0] py2;
  logic signed [15:0] nx2;
  logic signed [15:0] ny2;
  logic signed [15:0] nz2;
  logic signed [15:0] ct2;
  logic signed [15:0] st2;

  logic signed [49:0] px3;
  logic signed [49:0] pz3;
  logic signed [16:0] py3;
  logic signed [15:0] nx3;
  logic signed [15:0] ny3;
  logic signed [15:0] nz3;

  logic signed [17:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [17:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  logic signed [32:0] rsp_r;
  logic signed [31:0] nx_r;
  logic signed [31:0] nz_r;
  logic signed [49:0] px_r;
  logic signed [49:0] pz_r;

  assign rsp_r = rsp1 + 33'sd16384;
  assign nx_r  = nx1 + 32'sd16384;
  assign nz_r  = nz1 + 32'sd16384;
  assign px_r  = px3 + (50'sd1 <<< 29);
  assign pz_r  = pz3 + (50'sd1 <<< 29);

  always_ff @(posedge clk) begin
    if (en) begin
      rcp1 <= $signed({1'b0, minor_radius}) * cp;
      rsp1 <= $signed({1'b0, minor_radius}) * sp;
      nx1  <= cp * ct;
      nz1  <= cp * st;
      ny1  <= sp;
      ct1  <= ct;
      st1  <= st;

      tube2 <= $signed({3'b0, major_radius, 15'b0}) + 34'(rcp1);
      py2   <= rsp_r[31:15];
      nx2   <= nx_r[30:15];
      nz2   <= nz_r[30:15];
      ny2   <= ny1;
      ct2   <= ct1;
      st2   <= st1;

      px3 <= tube2 * ct2;
      pz3 <= tube2 * st2;
      py3 <= py2;
      nx3 <= nx2;
      ny3 <= ny2;
      nz3 <= nz2;

      pos_x  <= px_r[47:30];
      pos_z  <= pz_r[47:30];
      pos_y  <= py3;
      norm_x <= nx3;
      norm_y <= ny3;
      norm_z <= nz3;
    end
  end

  assign m_tdata = {1'b0, v_dly[TX_DL-1], u_dly[TX_DL-1], norm_z, norm_y, norm_x,
                    pos_z, pos_y, pos_x};
  assign m_tuser = oor_dly[LAT-1];

endmodule
